/* src/shsi_pkg.sv */
// Package for the string hash slot insert block: field widths, codes, the
// controller/datapath command and status structs and the table size clamp.
// No dependencies.
package shsi_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned PORT_TAG_W = 16;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned DIVIDEND_W = 16;
  localparam int unsigned CNT_W      = $clog2(DIVIDEND_W);

  localparam int unsigned HASH_MUL  = 31;
  localparam int unsigned CHAR_MUL  = 7;
  localparam int unsigned HASH_INIT = 1;
  localparam int unsigned MIN_SIZE  = 2;
  localparam int unsigned RESET_TABLE_SIZE = 1024;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_TAG_WIDTH   = 16;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_OCCUPIED  = 2'd1,
    ST_READ_DONE = 2'd2,
    ST_KEY_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic take;
    logic clear_wr;
    logic div_step;
    logic commit;
    logic mem_rd;
    logic respond;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_is_read;
    logic div_last;
    logic is_last;
    logic clear_done;
    logic out_busy;
  } ctl_sts_t;

  // Saturates a written table size into the range the hash can use.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned depth);
    logic [SIZE_W-1:0] r;
    r = v;
    if (32'(v) > depth) begin
      r = SIZE_W'(depth);
    end
    if (32'(r) < MIN_SIZE) begin
      r = SIZE_W'(MIN_SIZE);
    end
    return r;
  endfunction

endpackage

/* src/shsi_item_if.sv */
// Input item channel of the string hash slot insert block.
// Depends on shsi_pkg for the field widths.
interface shsi_item_if import shsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic [PORT_TAG_W-1:0] entry_tag;
  logic [KEY_W-1:0]  read_key;

  modport source (output valid, req_type, char_code, last_char, entry_tag, read_key,
                  input ready);
  modport sink (input valid, req_type, char_code, last_char, entry_tag, read_key,
                output ready);
endinterface

/* src/shsi_res_if.sv */
// Result item channel of the string hash slot insert block.
// Depends on shsi_pkg for the field widths.
interface shsi_res_if import shsi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [KEY_W-1:0]      slot_index;
  logic                  slot_valid;
  logic [PORT_TAG_W-1:0] slot_tag;

  modport source (output valid, status, slot_index, slot_valid, slot_tag, input ready);
  modport sink (input valid, status, slot_index, slot_valid, slot_tag, output ready);
endinterface

/* src/shsi_cfg_if.sv */
// Configuration write channel carrying the table_size register.
// Depends on shsi_pkg for the register width.
interface shsi_cfg_if import shsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

/* src/shsi_ctrl.sv */
// Sequencing state machine of the string hash slot insert block.
// Depends on shsi_pkg for the command and status structs.
module shsi_ctrl import shsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIN   = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_fire) begin
          state_d = sts_i.in_is_read ? S_READ : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.commit = 1'b1;
        state_d = sts_i.is_last ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.respond = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Once the clearing pass is over it never runs again until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLEAR |=> state_q != S_CLEAR)
    else $error("clearing pass re-entered");

endmodule

/* src/shsi_dp.sv */
// Datapath of the string hash slot insert block: size register, hash and
// serial remainder unit, slot memory and result register. Uses shsi_pkg.
module shsi_dp import shsi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned TAG_WIDTH   = DEF_TAG_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  shsi_item_if.sink  item_i,
  shsi_res_if.source result_o,
  shsi_cfg_if.sink   cfg_i,
  input  ctl_cmd_t   cmd_i,
  output ctl_sts_t   sts_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [SIZE_W-1:0]     size_q;
  logic [SIZE_W-1:0]     hash_q;
  logic [DIVIDEND_W-1:0] div_q;
  logic [SIZE_W-1:0]     rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  is_read_q;
  logic                  is_last_q;
  logic [KEY_W-1:0]      key_q;
  logic [TAG_WIDTH-1:0]  tag_q;
  logic [IDX_W-1:0]      clr_q;
  logic [TAG_WIDTH:0]    mem_q [TABLE_DEPTH];
  logic [TAG_WIDTH:0]    rd_q;
  logic                  out_valid_q;

  logic                  in_fire;
  logic [DIVIDEND_W-1:0] dividend;
  logic [SIZE_W:0]       rem_sh;
  logic [SIZE_W:0]       rem_sub;
  logic [63:0]           in_tag_ext;
  logic [31:0]           addr_ext;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  mem_we;
  logic [TAG_WIDTH:0]    wr_word;
  logic                  key_ok;
  logic                  ins_new;
  logic [TAG_WIDTH-1:0]  res_tag_w;
  logic [63:0]           res_tag_ext;
  status_e               res_status;
  logic [KEY_W-1:0]      res_index;
  logic                  res_valid;
  logic                  out_busy;

  // Configuration register, saturated on write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= clamp_size(SIZE_W'(RESET_TABLE_SIZE), TABLE_DEPTH);
    end else if (cfg_i.valid) begin
      size_q <= clamp_size(cfg_i.table_size, TABLE_DEPTH);
    end
  end

  // Input capture.
  assign item_i.ready = cmd_i.take;
  assign in_fire      = item_i.valid && cmd_i.take;
  assign in_tag_ext   = 64'(item_i.entry_tag);
  assign dividend     = 16'(HASH_MUL) * 16'(hash_q) + 16'(CHAR_MUL) * 16'(item_i.char_code);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_read_q <= item_i.req_type == REQ_READ;
      is_last_q <= item_i.last_char;
      key_q     <= item_i.read_key;
      tag_q     <= in_tag_ext[TAG_WIDTH-1:0];
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  assign rem_sh  = {rem_q, div_q[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, size_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      div_q <= dividend;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= {div_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= (rem_sh >= {1'b0, size_q}) ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= SIZE_W'(HASH_INIT);
    end else if (cmd_i.commit) begin
      hash_q <= is_last_q ? SIZE_W'(HASH_INIT) : rem_q;
    end
  end

  // Slot memory: valid bit on top of the tag.
  assign addr_ext = is_read_q ? 32'(key_q) : 32'(rem_q);
  assign rd_addr  = addr_ext[IDX_W-1:0];
  assign key_ok   = {1'b0, key_q} < size_q;
  assign ins_new  = !is_read_q && !rd_q[TAG_WIDTH];
  assign mem_we   = cmd_i.clear_wr || (cmd_i.respond && ins_new);
  assign wr_addr  = cmd_i.clear_wr ? clr_q : rd_addr;
  assign wr_word  = cmd_i.clear_wr ? '0 : {1'b1, tag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Result selection.
  always_comb begin
    res_status = ST_READ_DONE;
    res_index  = key_q;
    res_valid  = 1'b0;
    res_tag_w  = '0;
    if (is_read_q) begin
      if (!key_ok) begin
        res_status = ST_KEY_RANGE;
      end else if (rd_q[TAG_WIDTH]) begin
        res_valid = 1'b1;
        res_tag_w = rd_q[TAG_WIDTH-1:0];
      end
    end else begin
      res_index = rem_q[KEY_W-1:0];
      res_valid = 1'b1;
      if (rd_q[TAG_WIDTH]) begin
        res_status = ST_OCCUPIED;
        res_tag_w  = rd_q[TAG_WIDTH-1:0];
      end else begin
        res_status = ST_INSERTED;
        res_tag_w  = tag_q;
      end
    end
  end

  assign res_tag_ext = 64'(res_tag_w);

  // Output register decouples the result from the next item.
  assign out_busy = out_valid_q && !result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      result_o.status     <= res_status;
      result_o.slot_index <= res_index;
      result_o.slot_valid <= res_valid;
      result_o.slot_tag   <= res_tag_ext[PORT_TAG_W-1:0];
    end
  end

  assign result_o.valid = out_valid_q;

  assign sts_o.in_fire    = in_fire;
  assign sts_o.in_is_read = item_i.req_type == REQ_READ;
  assign sts_o.div_last   = cnt_q == CNT_W'(DIVIDEND_W - 1);
  assign sts_o.is_last    = is_last_q;
  assign sts_o.clear_done = clr_q == IDX_W'(TABLE_DEPTH - 1);
  assign sts_o.out_busy   = out_busy;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> rem_q < size_q)
    else $error("hash remainder not below table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.respond |-> !out_busy)
    else $error("result register overwritten while still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.status == ST_KEY_RANGE
      |-> !result_o.slot_valid && result_o.slot_tag == '0)
    else $error("out-of-range read reports slot contents");

endmodule

/* src/string_hash_slot_insert.sv */
// Top level of the string hash slot insert block; joins the controller and
// the datapath. Depends on shsi_pkg, the three channel interfaces, shsi_ctrl, shsi_dp.
//
//  channel   | dir | payload                                         | accepted when
//  item_i    | in  | req_type, char_code, last_char, entry_tag, key | valid && ready
//  result_o  | out | status, slot_index, slot_valid, slot_tag       | valid && ready
//  cfg_i     | in  | table_size                                      | valid && ready
//
// A non-final character passes the 16-step serial remainder unit and a commit
// state before the next item can be taken; a final character also passes the
// read and respond states, a read only those. After reset a clearing pass
// writes every slot once, during which no item is accepted; configuration
// writes are taken at any time. A stalled result holds in its output
// register; the next item with a result then waits in its last cycle and no
// further item is accepted until the output register frees up.
module string_hash_slot_insert import shsi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned TAG_WIDTH   = DEF_TAG_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  shsi_item_if.sink  item_i,
  shsi_res_if.source result_o,
  shsi_cfg_if.sink   cfg_i
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  shsi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  shsi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .result_o (result_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule

/* test/shsi_hash_checker.sv */
// Checker for the string hash slot insert block: watches the item, result and
// table size channels, predicts every result and compares field by field.
// Depends on shsi_pkg and the three channel interfaces.
module shsi_hash_checker import shsi_pkg::*; #(
  parameter int unsigned DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shsi_item_if        item,
  shsi_res_if         result,
  shsi_cfg_if         cfg,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e               status;
    logic [KEY_W-1:0]      slot;
    logic                  used;
    logic [PORT_TAG_W-1:0] tag;
  } slot_result_t;

  slot_result_t          slot_results_q[$];
  logic [SIZE_W-1:0]     size_reg;
  logic [KEY_W-1:0]      hash_acc;
  bit                    occupied [DEPTH];
  logic [PORT_TAG_W-1:0] stored_tag [DEPTH];
  int unsigned           mismatches;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at %0t: %s got %0d, predicted %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_result(input status_e st, input int unsigned slot, input logic used,
                             input logic [PORT_TAG_W-1:0] tag);
    slot_result_t r;
    r.status = st;
    r.slot   = KEY_W'(slot);
    r.used   = used;
    r.tag    = tag;
    slot_results_q = {slot_results_q, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned  modulus;
    int unsigned  next_hash;
    slot_result_t want;
    if (!rst_ni) begin
      size_reg = SIZE_W'(RESET_TABLE_SIZE);
      hash_acc = KEY_W'(HASH_INIT);
      for (int i = 0; i < DEPTH; i++) begin
        occupied[i] = 1'b0;
      end
      slot_results_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Results leave before the item of this edge is predicted; a result
      // can never belong to an item accepted at the same edge.
      if (result.valid && result.ready) begin
        if (slot_results_q.size() == 0) begin
          report("result with nothing predicted, status", result.status, 0);
        end else begin
          want = slot_results_q.pop_front();
          if (result.status !== want.status) begin
            report("status", result.status, want.status);
          end
          if (result.slot_index !== want.slot) begin
            report("slot_index", result.slot_index, want.slot);
          end
          if (result.slot_valid !== want.used) begin
            report("slot_valid", result.slot_valid, want.used);
          end
          if (result.slot_tag !== want.tag) begin
            report("slot_tag", result.slot_tag, want.tag);
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        size_reg = cfg.table_size;
      end

      if (item.valid && item.ready) begin
        modulus = size_reg;
        if (modulus < MIN_SIZE) begin
          modulus = MIN_SIZE;
        end
        if (modulus > DEPTH) begin
          modulus = DEPTH;
        end
        if (item.req_type == REQ_READ) begin
          if (item.read_key >= modulus) begin
            push_result(ST_KEY_RANGE, item.read_key, 1'b0, '0);
          end else if (occupied[item.read_key]) begin
            push_result(ST_READ_DONE, item.read_key, 1'b1, stored_tag[item.read_key]);
          end else begin
            push_result(ST_READ_DONE, item.read_key, 1'b0, '0);
          end
        end else begin
          next_hash = (HASH_MUL * hash_acc + CHAR_MUL * item.char_code) % modulus;
          if (item.last_char) begin
            hash_acc = KEY_W'(HASH_INIT);
            if (!occupied[next_hash]) begin
              occupied[next_hash]   = 1'b1;
              stored_tag[next_hash] = item.entry_tag;
              push_result(ST_INSERTED, next_hash, 1'b1, item.entry_tag);
            end else begin
              push_result(ST_OCCUPIED, next_hash, 1'b1, stored_tag[next_hash]);
            end
          end else begin
            hash_acc = KEY_W'(next_hash);
          end
        end
      end

      pending_o    <= slot_results_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* test/tb_string_hash_slot_insert.sv */
// Testbench top for string_hash_slot_insert: drives sentences, slot reads and
// table size writes with random pacing; shsi_hash_checker does the checking.
// Depends on shsi_pkg, the channel interfaces, the block and the checker.
module tb_string_hash_slot_insert;
  import shsi_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT   = 50000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned PHASE_ITEMS   = 215;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned chars_left;
  logic [SIZE_W-1:0] size_written;

  shsi_item_if item ();
  shsi_res_if  result ();
  shsi_cfg_if  cfg ();

  string_hash_slot_insert uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .result_o (result),
    .cfg_i    (cfg)
  );

  shsi_hash_checker #(.DEPTH(DEF_TABLE_DEPTH)) hash_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item         (item),
    .result       (result),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // The sender works in bursts; a spent burst is followed by a gap with valid low.
  task automatic offer_item(input logic req, input logic [CHAR_W-1:0] ch, input logic last,
                            input logic [PORT_TAG_W-1:0] tag, input logic [KEY_W-1:0] key);
    if (burst_left == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    item.valid     <= 1'b1;
    item.req_type  <= req;
    item.char_code <= ch;
    item.last_char <= last;
    item.entry_tag <= tag;
    item.read_key  <= key;
    do @(posedge clk_i); while (!item.ready);
  endtask

  task automatic read_slot(input logic [KEY_W-1:0] key);
    offer_item(REQ_READ, CHAR_W'($urandom()), 1'($urandom_range(0, 1)),
               PORT_TAG_W'($urandom()), key);
  endtask

  task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic last,
                           input logic [PORT_TAG_W-1:0] tag);
    offer_item(REQ_CHAR, ch, last, tag, KEY_W'($urandom()));
  endtask

  // Waits until every predicted result has arrived, then gives a character
  // that is still in the remainder unit time to finish.
  task automatic settle();
    item.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] v);
    settle();
    cfg.valid      <= 1'b1;
    cfg.table_size <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    size_written = v;
  endtask

  // Mostly well-formed sentences with reads mixed in; a few stray characters
  // with a random end mark break the sentence structure.
  task automatic random_phase(input int unsigned count);
    int unsigned roll;
    int unsigned span;
    logic        last;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        span = size_written;
        if (span < MIN_SIZE) span = MIN_SIZE;
        if (span > DEF_TABLE_DEPTH) span = DEF_TABLE_DEPTH;
        if ($urandom_range(0, 1) == 0) begin
          read_slot(KEY_W'($urandom_range(0, span - 1)));
        end else begin
          read_slot(KEY_W'($urandom()));
        end
      end else if (roll < 30) begin
        last = 1'($urandom_range(0, 1));
        feed_char(CHAR_W'($urandom()), last, PORT_TAG_W'($urandom()));
        if (last) chars_left = 0;
      end else begin
        if (chars_left == 0) begin
          chars_left = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        end
        feed_char(CHAR_W'($urandom()), chars_left == 1, PORT_TAG_W'($urandom()));
        chars_left--;
      end
    end
  endtask

  // Result receiver: random stall patterns, plus one long hold-off so that
  // the block backs up and stops taking items.
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    bit          held;
    taken = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result.valid && result.ready) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: result.ready <= 1'b1;
          1: result.ready <= ($urandom_range(0, 3) != 0);
          default: result.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned drain;
    int unsigned sizes [6];
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    item.valid     <= 1'b0;
    item.req_type  <= REQ_CHAR;
    item.char_code <= '0;
    item.last_char <= 1'b0;
    item.entry_tag <= '0;
    item.read_key  <= '0;
    cfg.valid      <= 1'b0;
    cfg.table_size <= SIZE_W'(RESET_TABLE_SIZE);
    burst_left   = 0;
    chars_left   = 0;
    size_written = SIZE_W'(RESET_TABLE_SIZE);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full table after reset: empty reads at both ends, insert then collide,
    // and a read in the middle of a sentence.
    read_slot(10'd0);
    read_slot(10'd1023);
    feed_char(8'd0, 1'b1, 16'h0000);
    feed_char(8'd0, 1'b1, 16'hFFFF);
    feed_char(8'd255, 1'b0, 16'h0000);
    read_slot(10'd31);
    feed_char(8'd255, 1'b1, 16'hFFFF);
    read_slot(10'd737);

    // A size of zero acts as two: keys from two on are out of range.
    set_table_size(11'd0);
    read_slot(10'd2);
    read_slot(10'd1023);
    read_slot(10'd1);
    feed_char(8'd1, 1'b1, 16'h5A5A);
    feed_char(8'd0, 1'b1, 16'hA5A5);
    feed_char(8'd2, 1'b1, 16'h1234);

    // The size changes in the middle of a sentence and saturates at the depth.
    feed_char(8'd200, 1'b0, 16'h0000);
    set_table_size(11'h7FF);
    feed_char(8'd3, 1'b1, 16'h8001);
    read_slot(10'd1023);
    read_slot(10'd1);

    set_table_size(11'd1);
    feed_char(8'd9, 1'b1, 16'h7FFE);
    read_slot(10'd0);
    set_table_size(11'd1025);
    read_slot(10'd1023);
    set_table_size(11'd2);
    read_slot(10'd2);
    read_slot(10'd1);

    sizes = '{1024, 7, 2047, 1, 300, 0};
    sizes[5] = $urandom_range(2, 1024);
    foreach (sizes[p]) begin
      set_table_size(SIZE_W'(sizes[p]));
      random_phase(PHASE_ITEMS);
    end

    item.valid <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
